// ----- rtl/pfcv_pkg.sv -----
// ----------------------------------------------------------------------------
// pfcv_pkg
// Shared types and constants for the PCM frame converter with volume.
// ----------------------------------------------------------------------------
package pfcv_pkg;

    // Sample and gain widths
    localparam int SAMPLE_W = 16;
    localparam int HALF_W   = 9;                  // clamped volume half, 0..256
    localparam int GAIN_W   = 17;                 // gain product, 0..0x10000
    localparam int VOL_W    = 32;
    localparam int CFG_IDX_W = 8;

    localparam logic [HALF_W-1:0] VOL_MAX = 9'h100;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAIN_VOLUME    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEAKER_VOLUME = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAIN_MUTE      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEAKER_MUTE   = 8'd3;

    localparam logic [VOL_W-1:0] VOLUME_RESET = 32'h0100_0100;

    // Source formats
    typedef enum logic {
        FMT_STEREO16 = 1'b0,
        FMT_MONO8    = 1'b1
    } t_format;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [GAIN_W-1:0]          t_gain;

    // Clamp a 16-bit volume half to 256
    function automatic logic [HALF_W-1:0] clamp_half(input logic [15:0] h);
        logic [HALF_W-1:0] r;
        if (h > 16'(VOL_MAX)) begin
            r = VOL_MAX;
        end else begin
            r = h[HALF_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/pfcv_scale.sv -----
// ----------------------------------------------------------------------------
// pfcv_scale
// Scales one signed sample by an unsigned gain and takes the result as an
// arithmetic shift right by 16 (floor of sample * gain / 65536).
// ----------------------------------------------------------------------------
module pfcv_scale (
    input  pfcv_pkg::t_sample i_sample,
    input  pfcv_pkg::t_gain   i_gain,
    output pfcv_pkg::t_sample o_sample
);
    import pfcv_pkg::*;

    logic signed [SAMPLE_W+GAIN_W:0] w_prod;

    // Gain is at most 0x10000, so bits 31..16 always hold the full result
    assign w_prod   = (SAMPLE_W+GAIN_W+1)'(i_sample) * $signed({1'b0, i_gain});
    assign o_sample = w_prod[SAMPLE_W+15:16];

endmodule

// ----- rtl/pcm_frame_convert_with_volume_top.sv -----
// Pipeline: two register stages, stage 1 holding the decoded samples and
// stage 2 the scaled output words.
// Throughput: one word per cycle; the input stalls only when both pipeline
// stages are full and the output is not taken.
// Gains are registered from the volume and mute registers, which a write updates.
// Synchronous active-low reset clears both stages, holds both readies
// low and loads volume 0x01000100 on both volume registers with mutes off.
// ----------------------------------------------------------------------------
// pcm_frame_convert_with_volume_top
// Converts stereo 16-bit big-endian or mono 8-bit unsigned frames to a signed
// left/right pair scaled by the main and speaker volume gains.
// ----------------------------------------------------------------------------
module pcm_frame_convert_with_volume_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [pfcv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pfcv_pkg::VOL_W-1:0]     i_cfg_data,

    // Input frames
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // first_byte, second_byte, third_byte, fourth_byte
    input  logic        s_axis_tuser,   // source_format
    input  logic        s_axis_tlast,   // last_in_block

    // Output samples
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // left_sample, right_sample
    output logic        m_axis_tlast    // last_out
);
    import pfcv_pkg::*;

    // Configuration registers
    logic [VOL_W-1:0] r_main_volume;
    logic [VOL_W-1:0] r_speaker_volume;
    logic             r_main_mute;
    logic             r_speaker_mute;

    // Registered gains
    t_gain r_gain_l, r_gain_r;
    t_gain n_gain_l, n_gain_r;

    // Stage 1: decoded samples
    logic    r_s1_valid;
    t_sample r_s1_left, r_s1_right;
    logic    r_s1_last;
    t_sample n_s1_left, n_s1_right;

    // Stage 2: scaled samples
    logic    r_s2_valid;
    t_sample r_s2_left, r_s2_right;
    logic    r_s2_last;
    t_sample w_scaled_l, w_scaled_r;

    logic    w_in_accept;
    logic    w_s1_advance;
    t_format w_format;

    // Not ready while in reset
    assign o_cfg_ready = i_rst_n;

    // Config writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_volume    <= VOLUME_RESET;
            r_speaker_volume <= VOLUME_RESET;
            r_main_mute      <= 1'b0;
            r_speaker_mute   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MAIN_VOLUME:    r_main_volume    <= i_cfg_data;
                REG_SPEAKER_VOLUME: r_speaker_volume <= i_cfg_data;
                REG_MAIN_MUTE:      r_main_mute      <= i_cfg_data[0];
                REG_SPEAKER_MUTE:   r_speaker_mute   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Per-channel gain: left from high halves, right from low halves
    always_comb begin
        if (r_main_mute || r_speaker_mute) begin
            n_gain_l = '0;
            n_gain_r = '0;
        end else begin
            n_gain_l = GAIN_W'(clamp_half(r_main_volume[31:16])
                              * clamp_half(r_speaker_volume[31:16]));
            n_gain_r = GAIN_W'(clamp_half(r_main_volume[15:0])
                              * clamp_half(r_speaker_volume[15:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_gain_l <= n_gain_l;
        r_gain_r <= n_gain_r;
    end

    // Pipeline handshake; input held off while in reset
    assign w_s1_advance  = !r_s2_valid || m_axis_tready;
    assign s_axis_tready = i_rst_n && (!r_s1_valid || w_s1_advance);
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    // Frame decode: mono becomes (byte - 128) << 8 on both channels
    assign w_format = t_format'(s_axis_tuser);
    always_comb begin
        unique case (w_format)
            FMT_MONO8: begin
                n_s1_left  = {~s_axis_tdata[7], s_axis_tdata[6:0], 8'h00};
                n_s1_right = n_s1_left;
            end
            FMT_STEREO16: begin
                n_s1_left  = {s_axis_tdata[7:0], s_axis_tdata[15:8]};
                n_s1_right = {s_axis_tdata[23:16], s_axis_tdata[31:24]};
            end
            default: begin
                n_s1_left  = '0;
                n_s1_right = '0;
            end
        endcase
    end

    // Stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_left  <= n_s1_left;
            r_s1_right <= n_s1_right;
            r_s1_last  <= s_axis_tlast;
        end
    end

    // Volume scaling
    pfcv_scale u_scale_l (
        .i_sample (r_s1_left),
        .i_gain   (r_gain_l),
        .o_sample (w_scaled_l)
    );

    pfcv_scale u_scale_r (
        .i_sample (r_s1_right),
        .i_gain   (r_gain_r),
        .o_sample (w_scaled_r)
    );

    // Stage 2 / output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s1_advance) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_advance && r_s1_valid) begin
            r_s2_left  <= w_scaled_l;
            r_s2_right <= w_scaled_r;
            r_s2_last  <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_s2_valid;
    assign m_axis_tdata  = {r_s2_right, r_s2_left};
    assign m_axis_tlast  = r_s2_last;

endmodule

// ----- bench/pcm_frame_convert_with_volume_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_frame_convert_with_volume_top_tb
// Self-checking bench for the PCM frame converter. Frames go in on the slave
// stream with random gaps. Output words are taken with random stalls. Each
// word is checked against a frame-by-frame prediction that uses a local copy
// of the volume and mute registers. Registers are rewritten only between
// phases, after the pipeline has drained.
// ----------------------------------------------------------------------------
module pcm_frame_convert_with_volume_top_tb;
    import pfcv_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_FRAMES  = 1100;
    localparam int PHASE_FRAMES   = 100;

    typedef struct packed {
        logic    last;
        t_sample right;
        t_sample left;
    } t_pcm_pair;

    // DUT ports
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [VOL_W-1:0]     i_cfg_data  = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // first_byte, second_byte, third_byte, fourth_byte
    logic        s_axis_tuser  = 1'b0; // source_format
    logic        s_axis_tlast  = 1'b0; // last_in_block
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // left_sample, right_sample
    logic        m_axis_tlast;         // last_out

    // Local copy of the registers
    logic [VOL_W-1:0] vol_main    = VOLUME_RESET;
    logic [VOL_W-1:0] vol_speaker = VOLUME_RESET;
    logic             mute_main    = 1'b0;
    logic             mute_speaker = 1'b0;

    t_pcm_pair   pending_pairs[$];
    bit          quiet = 1'b0;        // no gaps, no stalls while set
    int unsigned sink_wait = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned frames_sent = 0;
    int unsigned words_seen = 0;
    int unsigned reg_writes = 0;

    pcm_frame_convert_with_volume_top dut (.*);

    // 125 MHz clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [8:0] volume_half(input logic [15:0] h);
        return (h > 16'd256) ? 9'd256 : h[8:0];
    endfunction

    // upper = 1 selects the left half of both volume registers
    function automatic logic [16:0] channel_gain(input bit upper);
        logic [15:0] hm;
        logic [15:0] hs;
        logic [17:0] g;
        hm = upper ? vol_main[31:16]    : vol_main[15:0];
        hs = upper ? vol_speaker[31:16] : vol_speaker[15:0];
        g  = volume_half(hm) * volume_half(hs);
        if (mute_main || mute_speaker) begin
            g = '0;
        end
        return g[16:0];
    endfunction

    // floor(s * g / 65536), kept to 16 bits
    function automatic t_sample apply_gain(input t_sample s, input logic [16:0] g);
        logic signed [33:0] p;
        p = s * $signed({1'b0, g});
        return p[31:16];
    endfunction

    function automatic t_pcm_pair convert_frame(input t_format fmt, input logic [31:0] bytes,
                                               input logic last);
        t_pcm_pair r;
        t_sample   l;
        t_sample   rt;
        if (fmt == FMT_MONO8) begin
            l  = {bytes[7:0] - 8'd128, 8'h00};
            rt = l;
        end else begin
            l  = {bytes[7:0], bytes[15:8]};
            rt = {bytes[23:16], bytes[31:24]};
        end
        r.left  = apply_gain(l, channel_gain(1'b1));
        r.right = apply_gain(rt, channel_gain(1'b0));
        r.last  = last;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int unsigned draw_gap();
        return quiet ? 0 : $urandom_range(0, 5);
    endfunction

    // Leaves tvalid high so a zero-gap frame can follow in the same step
    task automatic send_frame(input t_format fmt, input logic [31:0] bytes, input logic last);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bytes;
        s_axis_tuser  <= fmt;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_pairs = {pending_pairs, convert_frame(fmt, bytes, last)};
        frames_sent++;
    endtask

    task automatic send_random_frame();
        send_frame(t_format'($urandom_range(0, 1)), $urandom(), $urandom_range(0, 7) == 0);
    endtask

    // Close the stream and let every expected word come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VOL_W-1:0] val);
        repeat ($urandom_range(1, 5)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            REG_MAIN_VOLUME:    vol_main     = val;
            REG_SPEAKER_VOLUME: vol_speaker  = val;
            REG_MAIN_MUTE:      mute_main    = val[0];
            REG_SPEAKER_MUTE:   mute_speaker = val[0];
            default: ;
        endcase
    endtask

    // New volume setting; the gain registers follow the written volume and mute registers
    task automatic set_volumes(input logic [31:0] vm, input logic [31:0] vs,
                               input logic [31:0] mm, input logic [31:0] ms);
        drain();
        write_reg(REG_MAIN_VOLUME, vm);
        write_reg(REG_SPEAKER_VOLUME, vs);
        write_reg(REG_MAIN_MUTE, mm);
        write_reg(REG_SPEAKER_MUTE, ms);
        repeat (3) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset gains pass samples unchanged: stereo extremes and mono range
    task automatic test_passthrough();
        send_frame(FMT_STEREO16, 32'hFF7F_0080, 1'b0);  // L 0x8000, R 0x7FFF
        send_frame(FMT_STEREO16, 32'h0080_FF7F, 1'b1);  // L 0x7FFF, R 0x8000
        send_frame(FMT_STEREO16, 32'h0000_0000, 1'b0);
        send_frame(FMT_STEREO16, 32'hFFFF_FFFF, 1'b1);
        send_frame(FMT_STEREO16, 32'h0100_0100, 1'b0);  // +1 on both
        send_frame(FMT_STEREO16, 32'h5AA5_C33C, 1'b0);
        // mono: unused bytes carry junk
        send_frame(FMT_MONO8, 32'hDEAD_BE00, 1'b0);
        send_frame(FMT_MONO8, 32'h1234_5680, 1'b1);
        send_frame(FMT_MONO8, 32'hFFFF_FFFF, 1'b0);
        send_frame(FMT_MONO8, 32'h0000_007F, 1'b0);
        drain();
    endtask

    // Attenuation, clamping of halves above 256, zero and full registers
    task automatic test_volume_steps();
        set_volumes(32'h0100_0080, 32'h0080_0100, 32'h0, 32'h0);
        send_frame(FMT_STEREO16, 32'hFF7F_0080, 1'b0);
        send_frame(FMT_MONO8, 32'h0000_0001, 1'b1);
        set_volumes(32'hFFFF_0101, 32'h0200_FFFF, 32'h0, 32'h0);
        send_frame(FMT_STEREO16, 32'hFF7F_0080, 1'b0);
        send_frame(FMT_STEREO16, 32'h0180_FF7F, 1'b0);
        set_volumes(32'h0001_0001, 32'h0001_0000, 32'h0, 32'h0);
        send_frame(FMT_STEREO16, 32'hFF7F_0080, 1'b1);
        send_frame(FMT_MONO8, 32'h0000_00FF, 1'b0);
        set_volumes(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_frame(FMT_STEREO16, 32'h0080_FF7F, 1'b0);
        drain();
    endtask

    // Each mute alone; only bit 0 of a mute write counts
    task automatic test_mutes();
        set_volumes(32'h0100_0100, 32'h0100_0100, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_frame(FMT_STEREO16, 32'hFF7F_0080, 1'b0);
        send_frame(FMT_MONO8, 32'h0000_00FF, 1'b1);
        set_volumes(32'h0100_0100, 32'h0100_0100, 32'h8000_0000, 32'h0000_0001);
        send_frame(FMT_STEREO16, 32'h0080_FF7F, 1'b0);
        set_volumes(32'h0100_0100, 32'h0100_0100, 32'hFFFF_FFFE, 32'h0000_0000);
        send_frame(FMT_STEREO16, 32'h0080_FF7F, 1'b1);
        drain();
    endtask

    // Writes to indexes past the register file change nothing
    task automatic test_bad_index();
        write_reg(REG_SPEAKER_MUTE + 8'd1, 32'h0000_0001);
        write_reg(8'hFF, 32'hFFFF_FFFF);
        write_reg(8'h80, 32'h0000_0000);
        repeat (3) @(posedge i_clk);
        send_frame(FMT_STEREO16, 32'hFF7F_0080, 1'b0);
        send_frame(FMT_MONO8, 32'h0000_0000, 1'b1);
        drain();
    endtask

    // Random frames in phases, each phase with its own volume setting
    task automatic test_random_stream();
        int unsigned phase;
        int unsigned k;
        logic [31:0] vm;
        logic [31:0] vs;
        for (phase = 0; phase < RANDOM_FRAMES / PHASE_FRAMES; phase++) begin
            case (phase)
                0: begin
                    vm = 32'hFFFF_FFFF;
                    vs = 32'hFFFF_FFFF;
                end
                1: begin
                    vm = 32'h0000_0000;
                    vs = 32'h0100_0100;
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        vm = $urandom();
                        vs = $urandom();
                    end else begin
                        vm = {16'($urandom_range(0, 300)), 16'($urandom_range(0, 300))};
                        vs = {16'($urandom_range(0, 300)), 16'($urandom_range(0, 300))};
                    end
                end
            endcase
            // mute words: random upper bits, bit 0 set now and then
            set_volumes(vm, vs,
                        {31'($urandom()), 1'($urandom_range(0, 5) == 0)},
                        {31'($urandom()), 1'($urandom_range(0, 5) == 0)});
            quiet = (phase % 4 == 3);
            for (k = 0; k < PHASE_FRAMES; k++) begin
                send_random_frame();
            end
            drain();
            quiet = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls and word check
    // ------------------------------------------------------------------
    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : sample_check
        t_pcm_pair want;
        if (m_axis_tvalid && m_axis_tready) begin
            words_seen++;
            if (pending_pairs.size() == 0) begin
                $display("%0t ns: unexpected word, expected none, actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                want = pending_pairs.pop_front();
                compare_field("left_sample", want.left, m_axis_tdata[15:0]);
                compare_field("right_sample", want.right, m_axis_tdata[31:16]);
                compare_field("last_out", {15'b0, want.last}, {15'b0, m_axis_tlast});
            end
            sink_wait = quiet ? 0 : $urandom_range(0, 5);
        end else if (sink_wait > 0) begin
            sink_wait--;
        end
        m_axis_tready <= (sink_wait == 0);
    end

    // Watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, idle_cycles);
            $display("pcm_frame_convert_with_volume_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_passthrough();
        test_volume_steps();
        test_mutes();
        test_bad_index();
        test_random_stream();
        drain();

        $display("Covered %0d frames and %0d output words, stereo and mono, under %0d",
                 frames_sent, words_seen, reg_writes);
        $display("register writes: clamped, zero, muted and full-scale gains, bad indexes.");
        if (mismatches == 0 && pending_pairs.size() == 0) begin
            $display("pcm_frame_convert_with_volume_top verification clean");
        end else begin
            $display("%0d mismatches, %0d words still expected", mismatches,
                     pending_pairs.size());
            $display("pcm_frame_convert_with_volume_top verification failed");
        end
        $finish;
    end

endmodule
